@@ hdl/lia_pkg.sv @@
// ----------------------------------------------------------------------------
// lia_pkg
// Shared types and opcodes for the integer ALU.
// ----------------------------------------------------------------------------
package lia_pkg;
  localparam int unsigned ModeW = 5;
  localparam int unsigned XW    = 64;

  localparam logic [ModeW-1:0] OpAdd   = 5'd0;
  localparam logic [ModeW-1:0] OpSub   = 5'd1;
  localparam logic [ModeW-1:0] OpMul   = 5'd2;
  localparam logic [ModeW-1:0] OpQuot  = 5'd3;
  localparam logic [ModeW-1:0] OpRem   = 5'd4;
  localparam logic [ModeW-1:0] OpFloor = 5'd5;
  localparam logic [ModeW-1:0] OpMod   = 5'd6;
  localparam logic [ModeW-1:0] OpEven  = 5'd7;
  localparam logic [ModeW-1:0] OpOdd   = 5'd8;
  localparam logic [ModeW-1:0] OpMax   = 5'd9;
  localparam logic [ModeW-1:0] OpMin   = 5'd10;
  localparam logic [ModeW-1:0] OpAnd   = 5'd11;
  localparam logic [ModeW-1:0] OpOr    = 5'd12;
  localparam logic [ModeW-1:0] OpXor   = 5'd13;
  localparam logic [ModeW-1:0] OpNot   = 5'd14;
  localparam logic [ModeW-1:0] OpShift = 5'd15;
  localparam logic [ModeW-1:0] OpPop   = 5'd16;

  function automatic logic is_div(logic [ModeW-1:0] m);
    return (m == OpQuot) || (m == OpRem) || (m == OpFloor) || (m == OpMod);
  endfunction
endpackage

@@ hdl/lia_if.sv @@
// ----------------------------------------------------------------------------
// lia_in_if / lia_out_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface lia_in_if;
  logic                       valid;
  logic                       ready;
  logic [4:0]                 mode;
  logic signed [63:0]         operand_a;
  logic signed [63:0]         operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface lia_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [63:0]         result_value;
  logic                       status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

@@ hdl/lia_cell.sv @@
// ----------------------------------------------------------------------------
// lia_cell
// One stage of the chain: one restoring divide step, one shift-add multiply
// step or one popcount bit on the carried word; other ops pass through.
// ----------------------------------------------------------------------------
module lia_cell #(
  parameter int unsigned W = 64,
  parameter int unsigned BIT = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [4:0]   mode_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] res_i,
  input  logic         st_i,
  output logic         vld_o,
  output logic [4:0]   mode_o,
  output logic [W-1:0] a_o,
  output logic [W-1:0] b_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] res_o,
  output logic         st_o
);
  import lia_pkg::*;

  logic [W-1:0] ub;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_d, quo_d;
  logic [W-1:0] pp;
  logic         pbit;

  always_comb begin
    ub    = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    trial = {rem_i, quo_i[W-1-BIT]};
    diff  = trial - {1'b0, ub};
    rem_d = diff[W] ? trial[W-1:0] : diff[W-1:0];
    quo_d = quo_i;
    quo_d[W-1-BIT] = ~diff[W];
    pp    = b_i[BIT] ? (a_i << BIT) : '0;
    // ones of a non-negative value, zeros of a negative one
    pbit  = a_i[BIT] ^ a_i[W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o <= mode_i;
      a_o    <= a_i;
      b_o    <= b_i;
      st_o   <= st_i;
      if (mode_i == OpMul) begin
        res_o <= res_i + pp;
      end else if (mode_i == OpPop) begin
        res_o <= res_i + W'(pbit);
      end else begin
        res_o <= res_i;
      end
      if (is_div(mode_i)) begin
        rem_o <= rem_d;
        quo_o <= quo_d;
      end else begin
        rem_o <= rem_i;
        quo_o <= quo_i;
      end
    end
  end
endmodule

@@ hdl/lia_front.sv @@
// ----------------------------------------------------------------------------
// lia_front
// Operand narrowing and the ops that need no cell of the chain.
// ----------------------------------------------------------------------------
module lia_front #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [4:0]   mode_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         vld_o,
  output logic [4:0]   mode_o,
  output logic [W-1:0] a_o,
  output logic [W-1:0] b_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] res_o,
  output logic         st_o
);
  import lia_pkg::*;

  logic [W-1:0] a, b, r, ua;
  logic [W-1:0] nb;
  logic         sa, lt;

  always_comb begin
    a   = a_i[W-1:0];
    b   = b_i[W-1:0];
    sa  = a[W-1];
    lt  = $signed(a) < $signed(b);
    ua  = sa ? (~a + 1'b1) : a;
    nb  = ~b + 1'b1;
    r = '0;
    case (mode_i)
      OpAdd:   r = a + b;
      OpSub:   r = a - b;
      OpEven:  r = W'(!a[0]);
      OpOdd:   r = W'(a[0]);
      OpMax:   r = lt ? b : a;
      OpMin:   r = lt ? a : b;
      OpAnd:   r = a & b;
      OpOr:    r = a | b;
      OpXor:   r = a ^ b;
      OpNot:   r = ~a;
      OpShift: begin
        if (!b[W-1]) r = (b >= W'(W)) ? '0 : (a << b);
        else         r = (nb >= W'(W)) ? {W{sa}} : W'($signed(a) >>> nb);
      end
      // multiply and popcount accumulate along the cells
      default: r = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o <= mode_i;
      a_o    <= a;
      b_o    <= b;
      quo_o  <= ua;
      res_o  <= r;
      st_o   <= is_div(mode_i) && (b == '0);
    end
  end
endmodule

@@ hdl/lia_fix.sv @@
// ----------------------------------------------------------------------------
// lia_fix
// Sign and floor correction after the divide chain; result register.
// ----------------------------------------------------------------------------
module lia_fix #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [4:0]   mode_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] res_i,
  input  logic         st_i,
  output logic         vld_o,
  output logic [63:0]  res_o,
  output logic         st_o
);
  import lia_pkg::*;

  logic         differ;
  logic [W-1:0] q, rm, r;

  always_comb begin
    differ = a_i[W-1] ^ b_i[W-1];
    q  = differ ? (~quo_i + 1'b1) : quo_i;
    rm = a_i[W-1] ? (~rem_i + 1'b1) : rem_i;
    r  = res_i;
    if (st_i) r = '0;
    else begin
      case (mode_i)
        OpQuot:  r = q;
        OpRem:   r = rm;
        OpFloor: r = (differ && rm != '0) ? q - 1'b1 : q;
        OpMod:   r = (differ && rm != '0) ? rm + b_i : rm;
        default: r = res_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= 64'($signed(r));
      st_o  <= st_i;
    end
  end
endmodule

@@ hdl/lisp_integer_alu_unit.sv @@
// ----------------------------------------------------------------------------
// lisp_integer_alu_unit
// Pipelined signed integer ALU with a chain of divide cells.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_if   | in  | mode, operand_a, operand_b
// out_if  | out | result_value, status
// One transfer per cycle while the output is not stalled; the stages in order are
// the front stage, one cell per quotient or multiplier bit and the fix-up stage.
// The whole pipe advances together; a stalled output holds every stage,
// empty slots included (ready only when the output register is empty or taken).
// Reset clears all valid bits only.
module lisp_integer_alu_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  lia_in_if.sink    in_if,
  lia_out_if.source out_if
);
  import lia_pkg::*;
  localparam int unsigned W = DATA_WIDTH;

  logic         en;
  logic         v   [W+1];
  logic [4:0]   m   [W+1];
  logic [W-1:0] a   [W+1];
  logic [W-1:0] b   [W+1];
  logic [W-1:0] rem [W+1];
  logic [W-1:0] quo [W+1];
  logic [W-1:0] res [W+1];
  logic         st  [W+1];

  assign en          = out_if.ready || !out_if.valid;
  assign in_if.ready = en;
  assign rem[0]      = '0;

  lia_front #(.W(W)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid), .mode_i(in_if.mode),
    .a_i(in_if.operand_a), .b_i(in_if.operand_b),
    .vld_o(v[0]), .mode_o(m[0]), .a_o(a[0]), .b_o(b[0]), .quo_o(quo[0]),
    .res_o(res[0]), .st_o(st[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    lia_cell #(.W(W), .BIT(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(v[i]), .mode_i(m[i]), .a_i(a[i]), .b_i(b[i]),
      .rem_i(rem[i]), .quo_i(quo[i]), .res_i(res[i]), .st_i(st[i]),
      .vld_o(v[i+1]), .mode_o(m[i+1]), .a_o(a[i+1]), .b_o(b[i+1]),
      .rem_o(rem[i+1]), .quo_o(quo[i+1]), .res_o(res[i+1]), .st_o(st[i+1])
    );
  end

  lia_fix #(.W(W)) u_fix (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v[W]), .mode_i(m[W]), .a_i(a[W]), .b_i(b[W]),
    .rem_i(rem[W]), .quo_i(quo[W]), .res_i(res[W]), .st_i(st[W]),
    .vld_o(out_if.valid), .res_o(out_if.result_value), .st_o(out_if.status)
  );
endmodule

@@ hdl/lia_checker.sv @@
// ----------------------------------------------------------------------------
// lia_checker
// Port-level checks for the integer ALU.
// ----------------------------------------------------------------------------
module lia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic        out_status
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status |-> out_result == 64'd0)
    else $error("divide by zero result not zero");
endmodule

bind lisp_integer_alu_unit lia_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_result(out_if.result_value), .out_status(out_if.status)
);
